>>> hdl/cfad_pkg.sv
// Shared types and constants for the control frame to actuator duty core.
package cfad_pkg;

   // Request kinds carried in req_tuser
   typedef enum logic [1:0] {
      CMD_BYTE  = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_OPEN  = 2'd2,
      CMD_CLOSE = 2'd3
   } cmd_type;

   // Why a result was produced, carried in rsp_tuser
   typedef enum logic [1:0] {
      CAUSE_FRAME = 2'd0,
      CAUSE_IDLE  = 2'd1,
      CAUSE_CLOSE = 2'd2
   } cause_type;

   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

   typedef enum logic [2:0] {
      REG_MOTOR_PERIOD = 3'd0,
      REG_SERVO_BASE   = 3'd1,
      REG_SERVO_SPAN   = 3'd2,
      REG_LIGHT_ONE    = 3'd3,
      REG_LIGHT_TWO    = 3'd4,
      REG_LIGHT_THREE  = 3'd5,
      REG_HOLD_MS      = 3'd6,
      REG_TIMEOUT_MS   = 3'd7
   } reg_index_type;

   // Frame layout
   localparam int          WINDOW_DEPTH = 9;
   localparam logic [7:0]  SYNC_FIRST   = 8'h5A;
   localparam logic [7:0]  SYNC_SECOND  = 8'hA5;
   localparam logic [7:0]  FRAME_KIND   = 8'h01;
   localparam logic [7:0]  FRAME_LENGTH = 8'd10;

   // Control value ranges
   localparam logic [10:0] CTRL_MID     = 11'd512;
   localparam logic [15:0] CTRL_MAX     = 16'd1024;
   localparam logic [1:0]  LIGHT_MAX    = 2'd3;

   // Register reset values
   localparam logic [23:0] MOTOR_PERIOD_RST = 24'd2000000;
   localparam logic [21:0] SERVO_BASE_RST   = 22'd500000;
   localparam logic [21:0] SERVO_SPAN_RST   = 22'd2000000;
   localparam logic [23:0] LIGHT_ONE_RST    = 24'd200000;
   localparam logic [23:0] LIGHT_TWO_RST    = 24'd500000;
   localparam logic [23:0] LIGHT_THREE_RST  = 24'd1000000;
   localparam logic [15:0] HOLD_MS_RST      = 16'd1000;
   localparam logic [15:0] TIMEOUT_MS_RST   = 16'd1000;

   // Decoded application handed from the frame stage to the duty stage
   typedef struct packed {
      cause_type   cause;
      logic [9:0]  magnitude;   // |throttle - 512|, zero when stopped
      dir_type     direction;
      logic        hold;
      logic [10:0] steering;
      logic [1:0]  light;
   } plan_type;

endpackage

>>> hdl/control_frame_to_actuator_duty_core.sv
// Top level: link deframer, reversal lockout and actuator duty generator.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  req     | in  | req_tvalid/tready    | tuser: command; tdata: byte_value
//  rsp     | out | rsp_tvalid/tready    | tuser: cause; tdata: duties, servo, flags
//  csr     | in  | csr_valid/csr_ready  | csr_index, csr_data (always ready)
//
// One request per cycle while rsp does not stall. A request that yields a result
// reaches rsp through two registers: the frame stage registers the decoded plan,
// the duty stage (one throttle and one steering multiplier) registers the result.
// Stalls on rsp back up through the two stages to req_tready without bubbles.
// reset is synchronous, active high: clears link, window, timers and lockout,
// loads the register defaults; no clearing pass is needed.
module control_frame_to_actuator_duty_core #(
   parameter int TIMER_BITS = 16,
   parameter int DUTY_BITS  = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] byte_value
   input  logic [1:0]                    req_tuser,   // [1:0] command
   // result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [23:0] forward_duty_ns, [47:24] reverse_duty_ns, [70:48] servo_pulse_ns,
   // [94:71] lamp_duty_ns, [96:95] motor_direction, [97] reversal_hold, [103:98] 0
   output logic [103:0]                  rsp_tdata,
   output logic [1:0]                    rsp_tuser,   // [1:0] cause
   // configuration write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [23:0]                   csr_data
);
   import cfad_pkg::*;

   localparam int CMP_BITS = (TIMER_BITS > 16) ? TIMER_BITS : 16;
   localparam int KEEP_BITS = (DUTY_BITS < 24) ? DUTY_BITS : 24;
   localparam logic [23:0] DUTY_MASK = 24'((64'd1 << KEEP_BITS) - 64'd1);

   // ---------------- configuration registers ----------------
   logic [23:0] motor_period_ff;
   logic [21:0] servo_base_ff;
   logic [21:0] servo_span_ff;
   logic [23:0] light_one_ff;
   logic [23:0] light_two_ff;
   logic [23:0] light_three_ff;
   logic [15:0] hold_ms_ff;
   logic [15:0] timeout_ms_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         motor_period_ff <= MOTOR_PERIOD_RST;
         servo_base_ff   <= SERVO_BASE_RST;
         servo_span_ff   <= SERVO_SPAN_RST;
         light_one_ff    <= LIGHT_ONE_RST;
         light_two_ff    <= LIGHT_TWO_RST;
         light_three_ff  <= LIGHT_THREE_RST;
         hold_ms_ff      <= HOLD_MS_RST;
         timeout_ms_ff   <= TIMEOUT_MS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_MOTOR_PERIOD: motor_period_ff <= csr_data;
            REG_SERVO_BASE:   servo_base_ff   <= csr_data[21:0];
            REG_SERVO_SPAN:   servo_span_ff   <= csr_data[21:0];
            REG_LIGHT_ONE:    light_one_ff    <= csr_data;
            REG_LIGHT_TWO:    light_two_ff    <= csr_data;
            REG_LIGHT_THREE:  light_three_ff  <= csr_data;
            REG_HOLD_MS:      hold_ms_ff      <= csr_data[15:0];
            REG_TIMEOUT_MS:   timeout_ms_ff   <= csr_data[15:0];
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic     plan_valid_ff, plan_valid_in;
   plan_type plan_ff, plan_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_load;
   logic     req_fire;
   logic     emit_now;

   assign rsp_load   = plan_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !plan_valid_ff || rsp_load;
   assign req_fire   = req_tvalid && req_tready;

   // ---------------- frame stage state ----------------
   logic [7:0]            window_ff [WINDOW_DEPTH];
   logic [7:0]            window_in [WINDOW_DEPTH];
   logic [3:0]            fill_ff, fill_in;
   dir_type               dir_ff, dir_in;
   logic                  hold_active_ff, hold_active_in;
   logic [TIMER_BITS-1:0] hold_elapsed_ff, hold_elapsed_in;
   logic [TIMER_BITS-1:0] idle_elapsed_ff, idle_elapsed_in;
   logic                  link_up_ff, link_up_in;

   // Walk one request through the deframer and the lockout rule.
   always_comb begin
      logic [7:0]  parity;
      logic [15:0] thr_raw;
      logic [15:0] ste_raw;
      logic [10:0] thr;
      logic [10:0] ste;
      logic [1:0]  lit;
      cause_type   cause;
      dir_type     want;

      window_in       = window_ff;
      fill_in         = fill_ff;
      dir_in          = dir_ff;
      hold_active_in  = hold_active_ff;
      hold_elapsed_in = hold_elapsed_ff;
      idle_elapsed_in = idle_elapsed_ff;
      link_up_in      = link_up_ff;
      emit_now        = 1'b0;
      thr             = CTRL_MID;
      ste             = CTRL_MID;
      lit             = '0;
      cause           = CAUSE_FRAME;
      want            = DIR_STOP;
      plan_in         = plan_ff;

      parity = '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         parity = parity ^ window_ff[i];
      end
      thr_raw = {window_ff[5], window_ff[4]};
      ste_raw = {window_ff[7], window_ff[6]};

      unique case (cmd_type'(req_tuser))
         CMD_BYTE: begin
            if (link_up_ff) begin
               idle_elapsed_in = '0;
               if (fill_ff < 4'(WINDOW_DEPTH)) begin
                  window_in[fill_ff] = req_tdata;
                  fill_in = fill_ff + 4'd1;
               end else if (window_ff[0] == SYNC_FIRST && window_ff[1] == SYNC_SECOND &&
                            window_ff[2] == FRAME_KIND && window_ff[3] == FRAME_LENGTH &&
                            parity == req_tdata) begin
                  thr      = (thr_raw > CTRL_MAX) ? 11'(CTRL_MAX) : thr_raw[10:0];
                  ste      = (ste_raw > CTRL_MAX) ? 11'(CTRL_MAX) : ste_raw[10:0];
                  lit      = (window_ff[8] > 8'(LIGHT_MAX)) ? LIGHT_MAX : window_ff[8][1:0];
                  fill_in  = '0;
                  cause    = CAUSE_FRAME;
                  emit_now = 1'b1;
               end else begin
                  // slide: drop the oldest byte
                  for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                     window_in[i] = window_ff[i+1];
                  end
                  window_in[WINDOW_DEPTH-1] = req_tdata;
               end
            end
         end
         CMD_TICK: begin
            if (hold_active_ff && !(&hold_elapsed_ff)) begin
               hold_elapsed_in = hold_elapsed_ff + 1'b1;
            end
            if (link_up_ff) begin
               idle_elapsed_in = (&idle_elapsed_ff) ? idle_elapsed_ff
                                                    : idle_elapsed_ff + 1'b1;
               if (CMP_BITS'(idle_elapsed_in) >= CMP_BITS'(timeout_ms_ff)) begin
                  idle_elapsed_in = '0;
                  cause    = CAUSE_IDLE;
                  emit_now = 1'b1;
               end
            end
         end
         CMD_OPEN: begin
            link_up_in      = 1'b1;
            idle_elapsed_in = '0;
         end
         CMD_CLOSE: begin
            link_up_in      = 1'b0;
            fill_in         = '0;
            idle_elapsed_in = '0;
            cause           = CAUSE_CLOSE;
            emit_now        = 1'b1;
         end
      endcase

      // Direction request and reversal lockout
      if (thr > CTRL_MID) begin
         want = DIR_FWD;
      end else if (thr < CTRL_MID) begin
         want = DIR_REV;
      end else begin
         want = DIR_STOP;
      end

      if (emit_now) begin
         if (hold_active_in) begin
            if (CMP_BITS'(hold_elapsed_in) < CMP_BITS'(hold_ms_ff)) begin
               want = DIR_STOP;
            end else begin
               hold_active_in  = 1'b0;
               hold_elapsed_in = '0;
            end
         end
         if (dir_ff != DIR_STOP && want != DIR_STOP && dir_ff != want) begin
            hold_active_in  = 1'b1;
            hold_elapsed_in = '0;
            want            = DIR_STOP;
         end
         dir_in = want;

         plan_in.cause     = cause;
         plan_in.direction = want;
         plan_in.hold      = hold_active_in;
         plan_in.steering  = ste;
         plan_in.light     = lit;
         unique case (want)
            DIR_FWD:  plan_in.magnitude = 10'(thr - CTRL_MID);
            DIR_REV:  plan_in.magnitude = 10'(CTRL_MID - thr);
            default:  plan_in.magnitude = '0;
         endcase
      end
   end

   always_comb begin
      plan_valid_in = plan_valid_ff;
      if (req_fire && emit_now) begin
         plan_valid_in = 1'b1;
      end else if (rsp_load) begin
         plan_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
         fill_ff         <= '0;
         dir_ff          <= DIR_STOP;
         hold_active_ff  <= 1'b0;
         hold_elapsed_ff <= '0;
         idle_elapsed_ff <= '0;
         link_up_ff      <= 1'b0;
         plan_valid_ff   <= 1'b0;
      end else begin
         if (req_fire) begin
            window_ff       <= window_in;
            fill_ff         <= fill_in;
            dir_ff          <= dir_in;
            hold_active_ff  <= hold_active_in;
            hold_elapsed_ff <= hold_elapsed_in;
            idle_elapsed_ff <= idle_elapsed_in;
            link_up_ff      <= link_up_in;
         end
         plan_valid_ff <= plan_valid_in;
      end
   end

   // Plan payload: advance only when a new plan comes in.
   always_ff @(posedge clock) begin
      if (req_fire && emit_now) begin
         plan_ff <= plan_in;
      end
   end

   // ---------------- duty stage ----------------
   logic [33:0]  motor_prod;
   logic [32:0]  servo_prod;
   logic [23:0]  motor_duty;
   logic [23:0]  fwd_duty;
   logic [23:0]  rev_duty;
   logic [22:0]  servo_pulse;
   logic [23:0]  lamp_duty;
   logic [103:0] rsp_data_ff, rsp_data_in;
   logic [1:0]   rsp_user_ff, rsp_user_in;

   // magnitude * period / 512 and steering * span / 1024
   assign motor_prod  = 34'(plan_ff.magnitude) * 34'(motor_period_ff);
   assign servo_prod  = 33'(plan_ff.steering) * 33'(servo_span_ff);
   assign motor_duty  = motor_prod[32:9] & DUTY_MASK;
   assign fwd_duty    = (plan_ff.direction == DIR_FWD) ? motor_duty : '0;
   assign rev_duty    = (plan_ff.direction == DIR_REV) ? motor_duty : '0;
   assign servo_pulse = 23'(servo_base_ff) + servo_prod[32:10];

   always_comb begin
      unique case (plan_ff.light)
         2'd0:    lamp_duty = '0;
         2'd1:    lamp_duty = light_one_ff & DUTY_MASK;
         2'd2:    lamp_duty = light_two_ff & DUTY_MASK;
         default: lamp_duty = light_three_ff & DUTY_MASK;
      endcase
   end

   assign rsp_data_in = {6'd0, plan_ff.hold, plan_ff.direction, lamp_duty,
                         servo_pulse, rev_duty, fwd_duty};
   assign rsp_user_in = plan_ff.cause;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTH
   // The window never holds more than a full frame minus its check byte.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 4'(WINDOW_DEPTH))
      else $error("window fill out of range");

   // A lockout always shows a stopped motor.
   a_hold_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[97] |-> rsp_tdata[96:95] == DIR_STOP)
      else $error("lockout reported with motor moving");

   // Only one bridge side is ever driven.
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:0] == '0 || rsp_tdata[47:24] == '0)
      else $error("both bridge sides driven");

   // A close takes the link down and empties the window.
   a_close: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == CMD_CLOSE |=> !link_up_ff && fill_ff == '0)
      else $error("close did not drop the link");
`endif

endmodule

>>> tb/control_frame_to_actuator_duty_checker.sv
// Checker for the control frame core: predicts each actuator result and compares it.
module control_frame_to_actuator_duty_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,    // [7:0] byte_value
   input  logic [1:0]   req_tuser,    // [1:0] command
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [23:0] forward, [47:24] reverse, [70:48] servo, [94:71] lamp,
   // [96:95] direction, [97] hold, [103:98] zero
   input  logic [103:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,    // [1:0] cause
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [23:0]  csr_data,
   output int           mismatches,
   output int           outstanding,
   output int           frames_applied,
   output int           idle_defaults,
   output int           close_defaults
);
   import cfad_pkg::*;

   typedef struct packed {
      cause_type   cause;
      logic [23:0] forward_ns;
      logic [23:0] reverse_ns;
      logic [22:0] servo_ns;
      logic [23:0] lamp_ns;
      dir_type     direction;
      logic        hold;
   } duty_result_type;

   duty_result_type duty_expect_q [$];

   logic [23:0] cfg [8];
   logic [7:0]  win [WINDOW_DEPTH];
   logic [3:0]  fill;
   dir_type     motor_dir;
   logic        hold_on;
   logic [15:0] hold_ms;
   logic [15:0] idle_ms;
   logic        link_on;
   int          errs, n_frame, n_idle, n_close;

   function automatic logic [23:0] reg_mask(input reg_index_type idx);
      case (idx)
         REG_SERVO_BASE, REG_SERVO_SPAN: return 24'h3F_FFFF;
         REG_HOLD_MS, REG_TIMEOUT_MS:    return 24'h00_FFFF;
         default:                        return 24'hFF_FFFF;
      endcase
   endfunction

   function automatic duty_result_type apply_controls(input cause_type cause,
         input logic [10:0] thr, input logic [10:0] ste, input logic [1:0] light);
      duty_result_type r;
      dir_type         want;
      logic [63:0]     scaled;
      r = '0;
      if (thr > CTRL_MID) want = DIR_FWD;
      else if (thr < CTRL_MID) want = DIR_REV;
      else want = DIR_STOP;
      // lockout: stop until the hold time has run, then release on this application
      if (hold_on) begin
         if (hold_ms < cfg[REG_HOLD_MS][15:0]) begin
            want = DIR_STOP;
         end else begin
            hold_on = 1'b0;
            hold_ms = '0;
         end
      end
      if (motor_dir != DIR_STOP && want != DIR_STOP && motor_dir != want) begin
         hold_on = 1'b1;
         hold_ms = '0;
         want    = DIR_STOP;
      end
      motor_dir = want;
      r.cause = cause;
      if (want == DIR_FWD) begin
         scaled = (64'(thr) - 64'(CTRL_MID)) * 64'(cfg[REG_MOTOR_PERIOD]) / 64'(CTRL_MID);
         r.forward_ns = scaled[23:0];
      end else if (want == DIR_REV) begin
         scaled = (64'(CTRL_MID) - 64'(thr)) * 64'(cfg[REG_MOTOR_PERIOD]) / 64'(CTRL_MID);
         r.reverse_ns = scaled[23:0];
      end
      scaled = 64'(cfg[REG_SERVO_BASE]) +
               64'(ste) * 64'(cfg[REG_SERVO_SPAN]) / 64'(CTRL_MAX);
      r.servo_ns = scaled[22:0];
      case (light)
         2'd1:    r.lamp_ns = cfg[REG_LIGHT_ONE];
         2'd2:    r.lamp_ns = cfg[REG_LIGHT_TWO];
         2'd3:    r.lamp_ns = cfg[REG_LIGHT_THREE];
         default: r.lamp_ns = '0;
      endcase
      r.direction = want;
      r.hold      = hold_on;
      return r;
   endfunction

   // Advance the link state by one request; returns 1 when a result follows.
   function automatic bit step_link(input cmd_type cmd, input logic [7:0] value,
         output duty_result_type r);
      logic [7:0]  sum;
      logic [15:0] thr_raw, ste_raw;
      logic [10:0] thr, ste;
      logic [1:0]  lit;
      bit          made;
      made = 1'b0;
      r    = '0;
      case (cmd)
         CMD_BYTE: begin
            if (link_on) begin
               idle_ms = '0;
               if (fill < WINDOW_DEPTH) begin
                  win[fill] = value;
                  fill++;
               end else begin
                  sum = '0;
                  for (int i = 0; i < WINDOW_DEPTH; i++) sum ^= win[i];
                  if (win[0] == SYNC_FIRST && win[1] == SYNC_SECOND &&
                      win[2] == FRAME_KIND && win[3] == FRAME_LENGTH && sum == value) begin
                     thr_raw = {win[5], win[4]};
                     ste_raw = {win[7], win[6]};
                     thr = (thr_raw > CTRL_MAX) ? CTRL_MAX[10:0] : thr_raw[10:0];
                     ste = (ste_raw > CTRL_MAX) ? CTRL_MAX[10:0] : ste_raw[10:0];
                     lit = (win[8] > 8'(LIGHT_MAX)) ? LIGHT_MAX : win[8][1:0];
                     fill = '0;
                     r = apply_controls(CAUSE_FRAME, thr, ste, lit);
                     made = 1'b1;
                  end else begin
                     for (int i = 0; i < WINDOW_DEPTH - 1; i++) win[i] = win[i + 1];
                     win[WINDOW_DEPTH - 1] = value;
                  end
               end
            end
         end
         CMD_TICK: begin
            if (hold_on && hold_ms != '1) hold_ms++;
            if (link_on) begin
               if (idle_ms != '1) idle_ms++;
               if (idle_ms >= cfg[REG_TIMEOUT_MS][15:0]) begin
                  idle_ms = '0;
                  r = apply_controls(CAUSE_IDLE, CTRL_MID, CTRL_MID, 2'd0);
                  made = 1'b1;
               end
            end
         end
         CMD_OPEN: begin
            link_on = 1'b1;
            idle_ms = '0;
         end
         default: begin
            link_on = 1'b0;
            fill    = '0;
            idle_ms = '0;
            r = apply_controls(CAUSE_CLOSE, CTRL_MID, CTRL_MID, 2'd0);
            made = 1'b1;
         end
      endcase
      return made;
   endfunction

   function automatic int check_field(input string name, input logic [23:0] want,
         input logic [23:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      duty_result_type pred, want;
      if (reset) begin
         cfg[REG_MOTOR_PERIOD] = MOTOR_PERIOD_RST;
         cfg[REG_SERVO_BASE]   = 24'(SERVO_BASE_RST);
         cfg[REG_SERVO_SPAN]   = 24'(SERVO_SPAN_RST);
         cfg[REG_LIGHT_ONE]    = LIGHT_ONE_RST;
         cfg[REG_LIGHT_TWO]    = LIGHT_TWO_RST;
         cfg[REG_LIGHT_THREE]  = LIGHT_THREE_RST;
         cfg[REG_HOLD_MS]      = 24'(HOLD_MS_RST);
         cfg[REG_TIMEOUT_MS]   = 24'(TIMEOUT_MS_RST);
         for (int i = 0; i < WINDOW_DEPTH; i++) win[i] = '0;
         fill      = '0;
         motor_dir = DIR_STOP;
         hold_on   = 1'b0;
         hold_ms   = '0;
         idle_ms   = '0;
         link_on   = 1'b0;
         duty_expect_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            cfg[csr_index] = csr_data & reg_mask(reg_index_type'(csr_index));
         if (rsp_tvalid && rsp_tready) begin
            if (duty_expect_q.size() == 0) begin
               $error("result with cause %0d arrived with nothing expected", rsp_tuser);
               errs++;
            end else begin
               want = duty_expect_q.pop_front();
               errs += check_field("cause", 24'(want.cause), 24'(rsp_tuser));
               errs += check_field("forward_duty_ns", want.forward_ns, rsp_tdata[23:0]);
               errs += check_field("reverse_duty_ns", want.reverse_ns, rsp_tdata[47:24]);
               errs += check_field("servo_pulse_ns", 24'(want.servo_ns), 24'(rsp_tdata[70:48]));
               errs += check_field("lamp_duty_ns", want.lamp_ns, rsp_tdata[94:71]);
               errs += check_field("motor_direction", 24'(want.direction),
                                   24'(rsp_tdata[96:95]));
               errs += check_field("reversal_hold", 24'(want.hold), 24'(rsp_tdata[97]));
               errs += check_field("padding", 24'd0, 24'(rsp_tdata[103:98]));
               case (want.cause)
                  CAUSE_FRAME: n_frame++;
                  CAUSE_IDLE:  n_idle++;
                  default:     n_close++;
               endcase
            end
         end
         if (req_tvalid && req_tready)
            if (step_link(cmd_type'(req_tuser), req_tdata, pred))
               duty_expect_q.push_back(pred);
      end
      mismatches     <= errs;
      outstanding    <= duty_expect_q.size();
      frames_applied <= n_frame;
      idle_defaults  <= n_idle;
      close_defaults <= n_close;
   end

endmodule

>>> tb/control_frame_to_actuator_duty_core_tb.sv
// Testbench top: drives link requests and register writes into the core and gives the verdict.
module control_frame_to_actuator_duty_core_tb;
   import cfad_pkg::*;

   // Receiver hold-off length used to back the pipeline up into req_tready
   localparam int HOLD_OFF_CYCLES = 300;
   // Cycles a request needs to clear both pipeline stages, plus margin
   localparam int SETTLE_CYCLES   = 6;

   typedef enum int {FLAW_NONE, FLAW_BIT, FLAW_CUT} flaw_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;    // [7:0] byte_value
   logic [1:0]   req_tuser = CMD_TICK;   // [1:0] command
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;         // duties, servo, direction, hold (see core ports)
   logic [1:0]   rsp_tuser;         // [1:0] cause
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = REG_MOTOR_PERIOD;
   logic [23:0]  csr_data = '0;

   int mismatches, outstanding, frames_applied, idle_defaults, close_defaults;

   // stimulus bookkeeping
   bit link_shadow = 1'b0;     // link state as the sender believes it
   bit calm = 1'b0;            // no gaps on either side while set
   int useful_items = 0;       // requests the core acts on
   int settings_written = 0;
   int squeezes_asked = 0;     // bumped by the sender to request a long hold-off
   int squeezes_done = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   control_frame_to_actuator_duty_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   control_frame_to_actuator_duty_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .frames_applied (frames_applied),
      .idle_defaults  (idle_defaults),
      .close_defaults (close_defaults)
   );

   // Mostly back-to-back, some short gaps, a few long ones; none while calm.
   function automatic int pick_gap();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Throttle or steering: mostly in range, with the midpoint, the clamp edge
   // and raw 16-bit values mixed in so every bit toggles.
   function automatic logic [15:0] pick_control();
      case ($urandom_range(0, 9))
         0:       return 16'(CTRL_MID);
         1, 2:    return 16'($urandom_range(0, 65535));
         3:       return 16'($urandom_range(1020, 1030));
         default: return 16'($urandom_range(0, 1024));
      endcase
   endfunction

   // Receiver: random ready with gaps; on request, hold off for a long stretch
   // so the core fills and stalls its input.
   initial begin : receiver
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (squeezes_asked != squeezes_done) begin
            squeezes_done = squeezes_asked;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            stall = pick_gap();
            if (stall == 0) begin
               rsp_tready <= 1'b1;
               @(posedge clock);
            end else begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   // Offer one request, after an optional gap, and hold it until accepted.
   task automatic send_req(input cmd_type cmd, input logic [7:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      if (!(cmd == CMD_BYTE && !link_shadow)) useful_items++;
      if (cmd == CMD_OPEN) link_shadow = 1'b1;
      if (cmd == CMD_CLOSE) link_shadow = 1'b0;
   endtask

   // Send a control frame; a flaw flips one bit or cuts the frame short.
   // Ticks may slip in between bytes, which must not disturb the window.
   task automatic send_frame(input logic [15:0] thr, input logic [15:0] ste,
         input logic [7:0] light, input flaw_type flaw);
      logic [7:0] frame_bytes [10];
      logic [7:0] sum;
      int         keep, i, flip_at, flip_bit;
      frame_bytes = '{SYNC_FIRST, SYNC_SECOND, FRAME_KIND, FRAME_LENGTH,
                      thr[7:0], thr[15:8], ste[7:0], ste[15:8], light, 8'h00};
      sum = '0;
      for (i = 0; i < 9; i++) sum ^= frame_bytes[i];
      frame_bytes[9] = sum;
      keep = 10;
      if (flaw == FLAW_BIT) begin
         flip_at  = $urandom_range(0, 9);
         flip_bit = $urandom_range(0, 7);
         frame_bytes[flip_at][flip_bit] = ~frame_bytes[flip_at][flip_bit];
      end else if (flaw == FLAW_CUT) begin
         keep = $urandom_range(1, 9);
      end
      for (i = 0; i < keep; i++) begin
         if ($urandom_range(0, 49) == 0) send_req(CMD_TICK, 8'($urandom()));
         send_req(CMD_BYTE, frame_bytes[i]);
      end
   endtask

   // Write every register once, in index order, while the core is idle.
   task automatic program_regs(input logic [23:0] period, input logic [23:0] base,
         input logic [23:0] span, input logic [23:0] one, input logic [23:0] two,
         input logic [23:0] three, input logic [23:0] hold_ms, input logic [23:0] timeout_ms);
      logic [23:0] plan [8];
      int          i;
      plan[REG_MOTOR_PERIOD] = period;
      plan[REG_SERVO_BASE]   = base;
      plan[REG_SERVO_SPAN]   = span;
      plan[REG_LIGHT_ONE]    = one;
      plan[REG_LIGHT_TWO]    = two;
      plan[REG_LIGHT_THREE]  = three;
      plan[REG_HOLD_MS]      = hold_ms;
      plan[REG_TIMEOUT_MS]   = timeout_ms;
      for (i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_index_type'(i);
         csr_data  <= plan[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      settings_written++;
   endtask

   // Drop valid, wait for every expected result (bounded), then let the
   // pipeline settle so no silent request is still in flight.
   task automatic drain(input int settle);
      int n;
      req_tvalid <= 1'b0;
      @(posedge clock);
      for (n = 0; n < 20000 && outstanding != 0; n++) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Random traffic: mostly well-formed frames, plus broken frames, noise,
   // ticks and link events. Budget counts only requests the core acts on.
   task automatic run_random(input int budget, input bit pause_midway);
      int  start, roll, n, next_mood;
      bit  paused;
      start     = useful_items;
      paused    = 1'b0;
      next_mood = start;
      while (useful_items - start < budget) begin
         // switch between gapped traffic and calm stretches
         if (useful_items >= next_mood) begin
            calm      = ($urandom_range(0, 3) == 0);
            next_mood = useful_items + 100;
         end
         // pause the sender until all expected results are back
         if (pause_midway && !paused && useful_items - start > budget / 2) begin
            paused = 1'b1;
            drain(0);
         end
         if (!link_shadow && $urandom_range(0, 3) != 0) send_req(CMD_OPEN, 8'($urandom()));
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            send_frame(pick_control(), pick_control(),
                       ($urandom_range(0, 4) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3)),
                       FLAW_NONE);
         end else if (roll < 65) begin
            send_frame(pick_control(), pick_control(), 8'($urandom()),
                       ($urandom_range(0, 1) == 0) ? FLAW_BIT : FLAW_CUT);
         end else if (roll < 75) begin
            for (n = $urandom_range(1, 6); n > 0; n--) send_req(CMD_BYTE, 8'($urandom()));
         end else if (roll < 90) begin
            for (n = $urandom_range(1, 6); n > 0; n--) send_req(CMD_TICK, 8'($urandom()));
         end else if (roll < 95) begin
            send_req(CMD_OPEN, 8'($urandom()));
         end else begin
            send_req(CMD_CLOSE, 8'($urandom()));
         end
      end
      calm = 1'b0;
   endtask

   initial begin : stimulus
      int n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: short hold and timeout so every rule shows up quickly
      program_regs(24'(MOTOR_PERIOD_RST), 24'(SERVO_BASE_RST), 24'(SERVO_SPAN_RST),
                   LIGHT_ONE_RST, LIGHT_TWO_RST, LIGHT_THREE_RST, 24'd2, 24'd4);
      send_req(CMD_BYTE, SYNC_FIRST);          // link down: ignored
      send_req(CMD_CLOSE, 8'hFF);              // close while down still applies defaults
      send_req(CMD_OPEN, 8'h00);
      send_frame(16'hFFFF, 16'hFFFF, 8'hFF, FLAW_NONE);   // all fields clamp, full forward
      send_frame(16'h0000, 16'h0000, 8'h01, FLAW_NONE);   // reversal request starts the hold
      send_req(CMD_TICK, 8'h00);
      send_req(CMD_TICK, 8'hFF);
      send_frame(16'h0000, 16'(CTRL_MAX), 8'h02, FLAW_NONE);  // hold expired: full reverse
      send_frame(16'(CTRL_MID), 16'(CTRL_MID), 8'h00, FLAW_NONE);  // stop
      send_req(CMD_BYTE, SYNC_FIRST);          // stray byte, then a cut frame: window slides
      send_frame(16'd700, 16'd300, 8'h03, FLAW_CUT);
      send_frame(16'd700, 16'd300, 8'h03, FLAW_NONE);
      send_frame(16'd513, 16'd1, 8'h01, FLAW_BIT);        // bad checksum or header
      send_frame(16'd513, 16'd1, 8'h01, FLAW_NONE);
      for (n = 0; n < 5; n++) send_req(CMD_TICK, 8'h55); // idle timeout
      send_req(CMD_OPEN, 8'hAA);               // open while up keeps the window
      send_req(CMD_CLOSE, 8'h00);
      drain(SETTLE_CYCLES);

      // Mid-range random settings; the sender pauses once mid-phase
      program_regs(24'($urandom_range(1, 16777215)), 24'($urandom_range(0, 4194303)),
                   24'($urandom_range(0, 4194303)), 24'($urandom()), 24'($urandom()),
                   24'($urandom()), 24'($urandom_range(0, 12)), 24'($urandom_range(1, 30)));
      run_random(400, 1'b1);
      drain(SETTLE_CYCLES);

      // All registers at their maximum; the long hold keeps the motor stopped
      program_regs(24'hFF_FFFF, 24'h3F_FFFF, 24'h3F_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                   24'hFF_FFFF, 24'h00_FFFF, 24'h00_FFFF);
      send_req(CMD_OPEN, 8'h00);
      send_frame(16'(CTRL_MAX), 16'h0000, 8'h00, FLAW_NONE);
      send_frame(16'h0000, 16'(CTRL_MAX), 8'h03, FLAW_NONE);   // hold starts
      send_req(CMD_CLOSE, 8'h00);              // link down: idle timer frozen
      calm = 1'b1;
      for (n = 0; n < 40; n++) send_req(CMD_TICK, 8'($urandom()));
      calm = 1'b0;
      send_req(CMD_OPEN, 8'h00);
      send_frame(16'd900, 16'd512, 8'h02, FLAW_NONE);          // hold still forces a stop
      run_random(300, 1'b0);
      drain(SETTLE_CYCLES);

      // All registers zero: every tick times out, hold releases at once.
      // Hold off the receiver while ticks keep coming so the core backs up.
      program_regs('0, '0, '0, '0, '0, '0, '0, '0);
      send_req(CMD_OPEN, 8'h00);
      squeezes_asked <= squeezes_asked + 1;
      for (n = 0; n < 60; n++) send_req(CMD_TICK, 8'($urandom()));
      run_random(300, 1'b0);
      drain(SETTLE_CYCLES);

      // Raw 24-bit writes: narrower registers must drop their upper bits
      program_regs(24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()),
                   24'($urandom()), 24'($urandom()),
                   {8'($urandom()), 16'($urandom_range(0, 6))},
                   {8'($urandom()), 16'($urandom_range(0, 8))});
      run_random(400, 1'b0);
      drain(SETTLE_CYCLES);

      // Back to the reset values, with the long timers
      program_regs(24'(MOTOR_PERIOD_RST), 24'(SERVO_BASE_RST), 24'(SERVO_SPAN_RST),
                   LIGHT_ONE_RST, LIGHT_TWO_RST, LIGHT_THREE_RST,
                   24'(HOLD_MS_RST), 24'(TIMEOUT_MS_RST));
      run_random(300, 1'b0);
      drain(SETTLE_CYCLES);

      $display("covered %0d link requests across %0d register settings",
               useful_items, settings_written);
      $display("checked %0d frame results, %0d idle timeouts, %0d link closes",
               frames_applied, idle_defaults, close_defaults);
      if (outstanding != 0)
         $error("%0d expected results never arrived", outstanding);
      if (mismatches == 0 && outstanding == 0)
         $display("control_frame_to_actuator_duty_core regression: pass");
      else
         $display("control_frame_to_actuator_duty_core regression: fail");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin : watchdog
      #20000000;
      $display("control_frame_to_actuator_duty_core regression: fail");
      $finish;
   end

endmodule

>>> files.f
hdl/cfad_pkg.sv
hdl/control_frame_to_actuator_duty_core.sv
tb/control_frame_to_actuator_duty_checker.sv
tb/control_frame_to_actuator_duty_core_tb.sv
